// ===== rtl/spadj_pkg.sv =====
// Shared types and constants of the shortest path block: item payloads,
// sequencer phases, pass control and register codes.
// No dependencies.
package spadj_pkg;

    localparam int RESULT_LIMIT = 64;
    localparam int VIDX_W       = 6;
    localparam int CNT_W        = 7;
    localparam int EW_W         = 16;
    localparam int DIST_W       = 23;
    localparam int OUT_DIST_W   = 22;

    localparam logic [DIST_W-1:0] DIST_INF = '1;

    localparam logic REG_SOURCE_VERTEX = 1'b0;
    localparam logic REG_VERTEX_COUNT  = 1'b1;

    typedef struct packed {
        logic [VIDX_W-1:0] row_vertex;
        logic [VIDX_W-1:0] col_vertex;
        logic [EW_W-1:0]   edge_weight;
        logic              load_last;
    } t_in_item;

    typedef struct packed {
        logic [VIDX_W-1:0]     vertex_index;
        logic [OUT_DIST_W-1:0] path_distance;
        logic                  reachable;
        logic                  result_last;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_LOAD,
        PH_START,
        PH_PASS,
        PH_MARK,
        PH_OUT
    } t_phase;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic relax_en;
        logic finished;
    } t_pass_ctl;

endpackage

// ===== rtl/shortest_path_adj_matrix.sv =====
// Loads an adjacency matrix of edge weights one item per cycle and, on the item
// marked load_last, runs a single-source shortest path search from the source
// register over the first vertex_count vertices. Weights live in a RAM of
// MAX_VERTICES squared entries; distances live in a RAM with one entry per vertex.
// The search runs n passes over the distance RAM (n = vertices in use, at most
// 64), each pass reading one vertex per cycle, relaxing it against the vertex
// finished last and tracking the next minimum. Results then leave in vertex order,
// one at a time: the next is read only once the last read has landed and the
// output has room. No input item is taken from load_last until the last result
// is delivered. Depends on spadj_pkg, spadj_ram and spadj_relax.
module shortest_path_adj_matrix
    import spadj_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = (MAX_VERTICES < RESULT_LIMIT) ? MAX_VERTICES : RESULT_LIMIT;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = IW + 1;
    localparam int WAW   = $clog2(MAX_VERTICES * MAX_VERTICES);

    logic [VIDX_W-1:0] r_source;
    logic [CNT_W-1:0]  r_count;

    t_phase            r_phase;
    t_phase            n_phase;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_round;
    logic [IW-1:0]     r_src;
    logic [DIST_W-1:0] r_src_dist;
    logic              r_relax_en;
    logic [DEPTH-1:0]  r_fin;
    logic [DEPTH-1:0]  r_dvld;
    t_pass_ctl         r_stage;
    t_pass_ctl         n_stage;
    logic [IW-1:0]     r_stage_idx;
    logic              r_rd_pend;
    logic              r_out_vld;
    t_out_item         r_out;

    logic              cfg_wr;
    logic              in_take;
    logic              out_take;
    logic              row_ok;
    logic [CNT_W-1:0]  cnt_nz;
    logic [CNT_W-1:0]  cnt_used;
    logic [CW-1:0]     w_n;
    logic              src_ok;
    logic [IW-1:0]     src_idx;
    logic              issue_pass;
    logic              issue_out;

    logic              dist_wr_en;
    logic [IW-1:0]     dist_wr_addr;
    logic [DIST_W-1:0] dist_wr_data;
    logic [DIST_W-1:0] dist_rd_data;
    logic [DIST_W-1:0] dist_eff;
    logic              wt_wr_en;
    logic [WAW-1:0]    wt_wr_addr;
    logic [WAW-1:0]    wt_rd_addr;
    logic [WEIGHT_BITS-1:0] wt_rd_data;

    logic              w_wr_en;
    logic [DIST_W-1:0] w_wr_dist;
    logic [DIST_W-1:0] w_best;
    logic [IW-1:0]     w_pick;
    logic              w_done;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source <= '0;
            r_count  <= CNT_W'(RESULT_LIMIT);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_SOURCE_VERTEX: r_source <= pwdata[VIDX_W-1:0];
                REG_VERTEX_COUNT:  r_count  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SOURCE_VERTEX: prdata = 32'(r_source);
            REG_VERTEX_COUNT:  prdata = 32'(r_count);
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        cnt_nz   = (r_count == '0) ? CNT_W'(1) : r_count;
        cnt_used = (cnt_nz > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cnt_nz;
        w_n      = CW'(cnt_used);
        src_ok   = CNT_W'(r_source) < CNT_W'(w_n);
        src_idx  = IW'(r_source);
        row_ok   = (int'(i_in_item.row_vertex) < MAX_VERTICES) &&
                   (int'(i_in_item.col_vertex) < MAX_VERTICES);
    end

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_LOAD: begin
                if (in_take && i_in_item.load_last) begin
                    n_phase = PH_START;
                end
            end
            PH_START: n_phase = PH_PASS;
            PH_PASS: begin
                if (w_done) begin
                    n_phase = (r_round + CW'(1) == w_n) ? PH_OUT : PH_MARK;
                end
            end
            PH_MARK: n_phase = PH_PASS;
            PH_OUT: begin
                if (out_take && r_out.result_last) begin
                    n_phase = PH_LOAD;
                end
            end
            default: n_phase = PH_LOAD;
        endcase
    end

    always_comb begin
        o_in_stall = (r_phase != PH_LOAD);
        in_take    = i_in_valid && !o_in_stall;
        out_take   = r_out_vld && !i_out_stall;
        issue_pass = (r_phase == PH_PASS) && (r_cnt < w_n);
        issue_out  = (r_phase == PH_OUT) && (r_cnt < w_n) && !r_rd_pend &&
                     (!r_out_vld || out_take);

        n_stage.valid    = issue_pass;
        n_stage.first    = (r_cnt == '0);
        n_stage.last     = (r_cnt + CW'(1) == w_n);
        n_stage.relax_en = r_relax_en;
        n_stage.finished = r_fin[r_cnt[IW-1:0]];

        dist_wr_en   = ((r_phase == PH_START) && src_ok) || w_wr_en;
        dist_wr_addr = (r_phase == PH_START) ? src_idx : r_stage_idx;
        dist_wr_data = (r_phase == PH_START) ? '0 : w_wr_dist;
        dist_eff     = r_dvld[r_stage_idx] ? dist_rd_data : DIST_INF;

        wt_wr_en   = in_take && row_ok;
        wt_wr_addr = WAW'(WAW'(i_in_item.row_vertex) * WAW'(MAX_VERTICES) +
                          WAW'(i_in_item.col_vertex));
        wt_rd_addr = WAW'(WAW'(r_src) * WAW'(MAX_VERTICES) + WAW'(r_cnt[IW-1:0]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LOAD;
            r_cnt      <= '0;
            r_round    <= '0;
            r_relax_en <= 1'b0;
            r_fin      <= '0;
            r_dvld     <= '0;
            r_stage    <= '0;
            r_rd_pend  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_stage   <= n_stage;
            r_rd_pend <= issue_out;
            if (r_rd_pend) begin
                r_out_vld <= 1'b1;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
            case (r_phase)
                PH_START: begin
                    r_fin      <= '0;
                    r_dvld     <= src_ok ? (DEPTH'(1) << src_idx) : '0;
                    r_cnt      <= '0;
                    r_round    <= '0;
                    r_relax_en <= 1'b0;
                end
                PH_PASS: begin
                    if (issue_pass) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (w_wr_en) begin
                        r_dvld[r_stage_idx] <= 1'b1;
                    end
                    if (w_done) begin
                        r_round <= r_round + CW'(1);
                        r_cnt   <= '0;
                    end
                end
                PH_MARK: begin
                    r_fin[w_pick] <= 1'b1;
                    r_relax_en    <= (w_best != DIST_INF);
                    r_cnt         <= '0;
                end
                PH_OUT: begin
                    if (issue_out) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage_idx <= r_cnt[IW-1:0];
        if (r_phase == PH_MARK) begin
            r_src      <= w_pick;
            r_src_dist <= w_best;
        end
        if (r_rd_pend) begin
            r_out.vertex_index  <= VIDX_W'(r_stage_idx);
            r_out.reachable     <= (dist_eff != DIST_INF);
            r_out.path_distance <= (dist_eff != DIST_INF) ?
                                   dist_eff[OUT_DIST_W-1:0] : '0;
            r_out.result_last   <= (CW'(r_stage_idx) + CW'(1) == w_n);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    spadj_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_VERTICES * MAX_VERTICES)
    ) u_weight_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wt_wr_en),
        .i_wr_addr (wt_wr_addr),
        .i_wr_data (WEIGHT_BITS'(i_in_item.edge_weight)),
        .i_rd_addr (wt_rd_addr),
        .o_rd_data (wt_rd_data)
    );

    spadj_ram #(
        .WIDTH (DIST_W),
        .DEPTH (DEPTH)
    ) u_dist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (dist_wr_en),
        .i_wr_addr (dist_wr_addr),
        .i_wr_data (dist_wr_data),
        .i_rd_addr (r_cnt[IW-1:0]),
        .o_rd_data (dist_rd_data)
    );

    spadj_relax #(
        .IW          (IW),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_relax (
        .i_clk      (i_clk),
        .i_ctl      (r_stage),
        .i_idx      (r_stage_idx),
        .i_dist     (dist_eff),
        .i_src_dist (r_src_dist),
        .i_weight   (wt_rd_data),
        .o_wr_en    (w_wr_en),
        .o_wr_dist  (w_wr_dist),
        .o_best     (w_best),
        .o_pick     (w_pick),
        .o_done     (w_done)
    );

    a_no_write_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_phase == PH_PASS) && !r_fin[r_stage_idx])
        else $error("distance update to a finished vertex");

    a_rounds_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_OUT && $past(r_phase) == PH_PASS) |-> (r_round == w_n))
        else $error("result burst started before all passes completed");

    a_out_in_out_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_phase == PH_OUT))
        else $error("result item outside the result burst");

    a_reload_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && r_out.result_last) |=> !o_in_stall && !o_out_valid)
        else $error("block did not return to loading after the last item");

endmodule

// ===== rtl/spadj_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module spadj_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/spadj_relax.sv =====
// Relaxation and minimum selection stage of one pass over the distance table.
// Depends on spadj_pkg.
module spadj_relax
    import spadj_pkg::*;
#(
    parameter int IW          = 6,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                   i_clk,
    input  t_pass_ctl              i_ctl,
    input  logic [IW-1:0]          i_idx,
    input  logic [DIST_W-1:0]      i_dist,
    input  logic [DIST_W-1:0]      i_src_dist,
    input  logic [WEIGHT_BITS-1:0] i_weight,
    output logic                   o_wr_en,
    output logic [DIST_W-1:0]      o_wr_dist,
    output logic [DIST_W-1:0]      o_best,
    output logic [IW-1:0]          o_pick,
    output logic                   o_done
);

    localparam int SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

    logic [DIST_W-1:0] r_best;
    logic [IW-1:0]     r_pick;
    logic [SUM_W-1:0]  cand;
    logic              upd;
    logic [DIST_W-1:0] new_dist;
    logic [DIST_W-1:0] base_best;
    logic [IW-1:0]     base_pick;
    logic              take;

    always_comb begin
        cand      = SUM_W'(i_src_dist) + SUM_W'(i_weight);
        upd       = i_ctl.valid && i_ctl.relax_en && !i_ctl.finished &&
                    (i_weight != '0) && (cand < SUM_W'(i_dist));
        new_dist  = upd ? cand[DIST_W-1:0] : i_dist;
        base_best = i_ctl.first ? DIST_INF : r_best;
        base_pick = i_ctl.first ? '0 : r_pick;
        take      = !i_ctl.finished && (new_dist <= base_best);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_best <= take ? new_dist : base_best;
            r_pick <= take ? i_idx : base_pick;
        end
    end

    assign o_wr_en   = upd;
    assign o_wr_dist = new_dist;
    assign o_best    = r_best;
    assign o_pick    = r_pick;
    assign o_done    = i_ctl.valid && i_ctl.last;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for shortest_path_adj_matrix: loads weight matrices, starts
// searches and compares every distance result against an in-bench Dijkstra.
// Depends on spadj_pkg and the shortest_path_adj_matrix RTL.
module tb;
    import spadj_pkg::*;

    localparam int          NV           = 64;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          SETTLE       = 20;
    localparam logic [2:0]  ADDR_SOURCE  = {REG_SOURCE_VERTEX, 2'b00};
    localparam logic [2:0]  ADDR_COUNT   = {REG_VERTEX_COUNT, 2'b00};

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_item   = '0;
    logic        gap_stall = 1'b0;
    logic        long_hold = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        out_stall;
    t_out_item   o_out_item;
    logic [31:0] prdata;
    logic        pready;

    t_in_item         pending_loads[$];
    t_out_item        expected_dists[$];
    logic [EW_W-1:0]  weight_copy [NV][NV];
    bit               entry_loaded [NV][NV];
    logic [5:0]       cfg_source = 6'd0;
    logic [6:0]       cfg_count  = 7'd64;
    int               idle_max = 8;
    int               in_wait = 0;
    int               out_wait = 0;
    int               loads_taken = 0;
    int               searches_run = 0;
    int               results_checked = 0;
    int               mismatches = 0;

    assign out_stall = gap_stall | long_hold;

    shortest_path_adj_matrix u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results still outstanding.", expected_dists.size());
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int used_vertices(input logic [6:0] cnt);
        if (cnt == 0) return 1;
        if (cnt > NV) return NV;
        return int'(cnt);
    endfunction

    function automatic logic [EW_W-1:0] draw_weight();
        case ($urandom_range(9, 0))
            0, 1, 2: return '0;
            3:       return 16'hFFFF;
            4:       return 16'd1;
            5, 6, 7: return EW_W'($urandom_range(20, 1));
            default: return EW_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 50) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    task automatic predict_search();
        int n;
        int pick;
        logic [DIST_W-1:0] best;
        logic [DIST_W-1:0] path_len [NV];
        bit                fin [NV];
        logic [DIST_W:0]   cand;
        t_out_item         r;
        n = used_vertices(cfg_count);
        for (int v = 0; v < n; v++) begin
            path_len[v] = DIST_INF;
            fin[v]      = 1'b0;
        end
        if (int'(cfg_source) < n) begin
            path_len[cfg_source] = '0;
            for (int k = 0; k + 1 < n; k++) begin
                best = DIST_INF;
                pick = 0;
                for (int v = 0; v < n; v++) begin
                    if (!fin[v] && path_len[v] <= best) begin
                        best = path_len[v];
                        pick = v;
                    end
                end
                fin[pick] = 1'b1;
                if (path_len[pick] != DIST_INF) begin
                    for (int v = 0; v < n; v++) begin
                        if (!fin[v] && weight_copy[pick][v] != 0) begin
                            cand = {1'b0, path_len[pick]} + weight_copy[pick][v];
                            if (cand < {1'b0, path_len[v]}) path_len[v] = cand[DIST_W-1:0];
                        end
                    end
                end
            end
        end
        for (int v = 0; v < n; v++) begin
            r.vertex_index  = VIDX_W'(v);
            r.reachable     = (path_len[v] != DIST_INF);
            r.path_distance = r.reachable ? path_len[v][OUT_DIST_W-1:0] : '0;
            r.result_last   = (v == n - 1);
            expected_dists.push_back(r);
        end
    endtask

    // Sender: one item at a time, with a random gap drawn after each accepted item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_wait = 0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid) in_wait = $urandom_range(idle_max, 0);
            if (in_wait > 0) begin
                in_wait--;
                in_valid <= 1'b0;
            end else if (pending_loads.size() > 0) begin
                in_item  <= pending_loads.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !o_in_stall) begin
            loads_taken++;
            weight_copy[in_item.row_vertex][in_item.col_vertex] = in_item.edge_weight;
            if (in_item.load_last) begin
                searches_run++;
                predict_search();
            end
        end
    end

    // Receiver: random stall after each accepted item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gap_stall <= 1'b0;
            out_wait = 0;
        end else begin
            if (o_out_valid && !out_stall) out_wait = $urandom_range(idle_max, 0);
            if (out_wait > 0) begin
                out_wait--;
                gap_stall <= 1'b1;
            end else begin
                gap_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            results_checked++;
            if (expected_dists.size() == 0) begin
                report_mismatch($sformatf("unexpected result for vertex %0d",
                                          o_out_item.vertex_index));
            end else begin
                want = expected_dists.pop_front();
                if (o_out_item.vertex_index !== want.vertex_index)
                    report_mismatch($sformatf("vertex_index %0d, want %0d",
                                              o_out_item.vertex_index, want.vertex_index));
                if (o_out_item.path_distance !== want.path_distance)
                    report_mismatch($sformatf("vertex %0d path_distance %0d, want %0d",
                                              want.vertex_index, o_out_item.path_distance,
                                              want.path_distance));
                if (o_out_item.reachable !== want.reachable)
                    report_mismatch($sformatf("vertex %0d reachable %0b, want %0b",
                                              want.vertex_index, o_out_item.reachable,
                                              want.reachable));
                if (o_out_item.result_last !== want.result_last)
                    report_mismatch($sformatf("vertex %0d result_last %0b, want %0b",
                                              want.vertex_index, o_out_item.result_last,
                                              want.result_last));
            end
        end
    end

    // Hold the output side off for a long stretch while the next graph is offered.
    initial begin
        do @(posedge i_clk); while (!(o_out_valid && searches_run >= 4));
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SOURCE) cfg_source = data[5:0];
        else cfg_count = data[6:0];
    endtask

    task automatic configure(input int src, input int cnt);
        write_reg(ADDR_SOURCE, 32'(src));
        write_reg(ADDR_COUNT, 32'(cnt));
    endtask

    task automatic load_entry(input int r, input int c, input logic [EW_W-1:0] w,
                              input bit last);
        t_in_item it;
        it.row_vertex  = VIDX_W'(r);
        it.col_vertex  = VIDX_W'(c);
        it.edge_weight = w;
        it.load_last   = last;
        entry_loaded[r][c] = 1'b1;
        pending_loads.push_back(it);
    endtask

    // Every entry of the block in use is loaded before its first search.
    task automatic fill_unloaded(input int n);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                if (!entry_loaded[r][c]) load_entry(r, c, draw_weight(), 1'b0);
    endtask

    task automatic build_graph(input int edges);
        int n;
        int r;
        int c;
        n = used_vertices(cfg_count);
        fill_unloaded(n);
        if (n > 1 && $urandom_range(1, 0)) begin
            for (int v = 0; v + 1 < n; v++)
                load_entry(v, v + 1, EW_W'($urandom_range(50, 1)), 1'b0);
        end
        for (int e = 0; e < edges; e++) begin
            if ($urandom_range(6, 0) == 0) begin
                r = $urandom_range(NV - 1, 0);
                c = $urandom_range(NV - 1, 0);
            end else begin
                r = $urandom_range(n - 1, 0);
                c = $urandom_range(n - 1, 0);
            end
            load_entry(r, c, draw_weight(), 1'b0);
        end
        load_entry($urandom_range(NV - 1, 0), $urandom_range(NV - 1, 0), draw_weight(), 1'b1);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_loads.size() != 0 || in_valid || expected_dists.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int n;
        int src;
        int cnt;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Small graph with ties, a maximum weight edge and an unreachable vertex.
        configure(0, 4);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                load_entry(r, c, '0, 1'b0);
        load_entry(0, 1, 16'hFFFF, 1'b0);
        load_entry(0, 2, 16'd1, 1'b0);
        load_entry(2, 1, 16'd1, 1'b0);
        load_entry(63, 63, 16'hFFFF, 1'b0);
        load_entry(2, 3, '0, 1'b1);
        wait_idle();
        // A vertex count of zero acts as a single vertex.
        configure(0, 0);
        load_entry(63, 0, 16'd1, 1'b1);
        wait_idle();
        // A source beyond the vertex count reaches nothing.
        configure(63, 3);
        load_entry(0, 63, '0, 1'b1);
        wait_idle();

        for (int p = 0; p < 3; p++) begin
            idle_max = (p % 3 == 2) ? 0 : 8;
            case ($urandom_range(9, 0))
                0:       cnt = 1;
                1:       cnt = 2;
                default: cnt = $urandom_range(5, 3);
            endcase
            n   = used_vertices(7'(cnt));
            src = ($urandom_range(4, 0) == 0) ? $urandom_range(NV - 1, 0)
                                              : $urandom_range(n - 1, 0);
            configure(src, cnt);
            for (int g = 0; g < 2; g++) build_graph($urandom_range(n + 1, 2));
            wait_idle();
        end

        // Oversized count caps at the full matrix; only the source row is followed.
        idle_max = 8;
        configure(63, 127);
        for (int c = 0; c + 1 < NV; c++)
            load_entry(63, c, '0, 1'b0);
        load_entry(63, 63, 16'hFFFF, 1'b1);
        wait_idle();

        $display("Covered %0d loaded items, %0d searches and %0d checked results.",
                 loads_taken, searches_run, results_checked);
        $display("Vertex counts 0 to 127, sources 0 to 63, and one %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
